// ===== src/hpbt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the header block tokenizer
// no dependencies

package hpbt_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_INT_INDEXED = 4'd1,
    PH_INT_NAMEIDX = 4'd2,
    PH_INT_UPDATE  = 4'd3,
    PH_NAMELEN_HDR = 4'd4,
    PH_INT_NAMELEN = 4'd5,
    PH_NAME_BYTES  = 4'd6,
    PH_VALLEN_HDR  = 4'd7,
    PH_INT_VALLEN  = 4'd8,
    PH_VALUE_BYTES = 4'd9
  } phase_t;

  // token kinds
  localparam logic [2:0] TK_INDEXED  = 3'd0;
  localparam logic [2:0] TK_NAME_IDX = 3'd1;
  localparam logic [2:0] TK_NAME_LEN = 3'd2;
  localparam logic [2:0] TK_VAL_LEN  = 3'd3;
  localparam logic [2:0] TK_STR_BYTE = 3'd4;
  localparam logic [2:0] TK_SIZE_UPD = 3'd5;
  localparam logic [2:0] TK_ERROR    = 3'd6;
  localparam logic [2:0] TK_BLK_END  = 3'd7;

  // error codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_BAD_TABLE = 3'd3;
  localparam logic [2:0] ST_INDEX0    = 3'd4;

  // literal kinds
  localparam logic [1:0] MODE_WITH    = 2'd0;
  localparam logic [1:0] MODE_WITHOUT = 2'd1;
  localparam logic [1:0] MODE_NEVER   = 2'd2;

  // largest shift before a continuation byte may still be added
  localparam logic [5:0] SHIFT_LIMIT = 6'd56;
  localparam logic [5:0] SHIFT_STEP  = 6'd7;

  localparam logic [31:0] TABLE_SIZE_RESET = 32'd4096;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        huff;
    logic [1:0]  mode;
    logic [7:0]  sbyte;
    logic [2:0]  status;
  } tok_t;

  // results of one input byte: one or two tokens
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } entry_t;

endpackage

// ===== src/hpack_header_block_tokenizer.sv =====
`timescale 1ns / 1ps
// HPACK header block tokenizer: accepts one header block byte per cycle while the
// internal queue has room and emits one token per cycle while pop is high. A byte
// gives zero, one or two tokens; a token is registered in the queue and then in the
// output register before it is visible. A byte that gives two tokens takes two pops,
// so sustained input rate is one byte per cycle as long as the result side pops one
// token per cycle and most bytes give at most one token; the QUEUE_DEPTH-entry
// queue absorbs bursts. The table size limit is written on cfg_data through the
// cfg_valid/cfg_ready channel, which is always ready. No clearing pass after reset.
// depends on hpbt_pkg, hpbt_front, hpbt_queue, hpbt_back

module hpack_header_block_tokenizer import hpbt_pkg::*; #(
  parameter int MAX_SIZE_UPDATES = 2,
  parameter int MAX_CONT_BYTES   = 10,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        block_start,
  input  logic        block_last,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  token_kind,
  output logic [63:0] token_value,
  output logic        huffman_flag,
  output logic [1:0]  index_mode,
  output logic [7:0]  string_byte,
  output logic [2:0]  status,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic   in_take;
  logic   ent_valid;
  entry_t ent;
  entry_t q_data;
  logic   q_rd;
  logic   q_empty;
  logic   q_full;
  tok_t   tok;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_take   = push && !q_full;

  hpbt_front #(
    .MAX_SIZE_UPDATES (MAX_SIZE_UPDATES),
    .MAX_CONT_BYTES   (MAX_CONT_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_take),
    .data_byte   (data_byte),
    .block_start (block_start),
    .block_last  (block_last),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .ent_valid   (ent_valid),
    .ent         (ent)
  );

  hpbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (ent_valid),
    .wr_data (ent),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  hpbt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .tok         (tok),
    .last_of_run (last_of_run)
  );

  // result fields
  assign token_kind   = tok.kind;
  assign token_value  = tok.value;
  assign huffman_flag = tok.huff;
  assign index_mode   = tok.mode;
  assign string_byte  = tok.sbyte;
  assign status       = tok.status;

endmodule

// ===== src/hpbt_front.sv =====
`timescale 1ns / 1ps
// front end: representation parser and prefix integer decoder, a byte per in_take
// depends on hpbt_pkg

module hpbt_front import hpbt_pkg::*; #(
  parameter int MAX_SIZE_UPDATES = 2,
  parameter int MAX_CONT_BYTES   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_take,
  input  logic [7:0]  data_byte,
  input  logic        block_start,
  input  logic        block_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        ent_valid,
  output entry_t      ent
);

  localparam int CC_W = $clog2(MAX_CONT_BYTES + 1);
  localparam int UC_W = $clog2(MAX_SIZE_UPDATES + 1);

  logic [31:0]     table_limit;
  phase_t          phase, phase_next;
  logic [63:0]     accum, accum_next;
  logic [5:0]      shift, shift_next;
  logic [CC_W-1:0] cont_cnt, cont_cnt_next;
  logic [63:0]     str_rem, str_rem_next;
  logic [1:0]      mode, mode_next;
  logic            upd_allowed, upd_allowed_next;
  logic [UC_W-1:0] upd_cnt, upd_cnt_next;
  logic            err, err_next;
  logic            huff, huff_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      table_limit <= cfg_data;
    end
  end

  // parse step
  always_comb begin
    phase_t      st_purpose;
    logic        st_go;
    logic [6:0]  st_pv;
    logic [6:0]  st_mask;
    logic        fin;
    phase_t      fin_purpose;
    logic [63:0] fin_v;
    logic [63:0] add;
    logic [64:0] sum;
    logic        p_valid, e_valid;
    tok_t        p_tok, e_tok;

    st_purpose  = PH_IDLE;
    st_go       = 1'b0;
    st_pv       = '0;
    st_mask     = '0;
    fin         = 1'b0;
    fin_purpose = PH_IDLE;
    fin_v       = '0;
    add         = '0;
    sum         = '0;
    p_valid     = 1'b0;
    e_valid     = 1'b0;
    p_tok       = '0;
    e_tok       = '0;

    // per-block state, cleared first when a new block opens
    if (block_start) begin
      phase_next       = PH_IDLE;
      accum_next       = '0;
      shift_next       = '0;
      cont_cnt_next    = '0;
      str_rem_next     = '0;
      mode_next        = MODE_WITH;
      upd_allowed_next = 1'b1;
      upd_cnt_next     = '0;
      err_next         = 1'b0;
      huff_next        = 1'b0;
    end else begin
      phase_next       = phase;
      accum_next       = accum;
      shift_next       = shift;
      cont_cnt_next    = cont_cnt;
      str_rem_next     = str_rem;
      mode_next        = mode;
      upd_allowed_next = upd_allowed;
      upd_cnt_next     = upd_cnt;
      err_next         = err;
      huff_next        = huff;
    end

    if (!err_next) begin
      case (phase_next)
        PH_IDLE: begin
          if (data_byte[7]) begin
            upd_allowed_next = 1'b0;
            st_go = 1'b1; st_purpose = PH_INT_INDEXED; st_mask = 7'h7F;
          end else if (data_byte[7:6] == 2'b01) begin
            upd_allowed_next = 1'b0;
            mode_next = MODE_WITH;
            st_go = 1'b1; st_purpose = PH_INT_NAMEIDX; st_mask = 7'h3F;
          end else if (data_byte[7:4] == 4'h0) begin
            upd_allowed_next = 1'b0;
            mode_next = MODE_WITHOUT;
            st_go = 1'b1; st_purpose = PH_INT_NAMEIDX; st_mask = 7'h0F;
          end else if (data_byte[7:4] == 4'h1) begin
            upd_allowed_next = 1'b0;
            mode_next = MODE_NEVER;
            st_go = 1'b1; st_purpose = PH_INT_NAMEIDX; st_mask = 7'h0F;
          end else if (!upd_allowed_next ||
                       upd_cnt_next >= UC_W'(MAX_SIZE_UPDATES)) begin
            p_valid = 1'b1; p_tok.kind = TK_ERROR; p_tok.status = ST_BAD_TABLE;
            err_next = 1'b1; phase_next = PH_IDLE;
          end else begin
            st_go = 1'b1; st_purpose = PH_INT_UPDATE; st_mask = 7'h1F;
          end
        end
        PH_INT_INDEXED, PH_INT_NAMEIDX, PH_INT_UPDATE,
        PH_INT_NAMELEN, PH_INT_VALLEN: begin
          if (cont_cnt_next >= CC_W'(MAX_CONT_BYTES) || shift_next > SHIFT_LIMIT) begin
            p_valid = 1'b1; p_tok.kind = TK_ERROR; p_tok.status = ST_OVERFLOW;
            err_next = 1'b1; phase_next = PH_IDLE;
          end else begin
            cont_cnt_next = cont_cnt_next + 1'b1;
            add = {57'd0, data_byte[6:0]} << shift_next;
            sum = {1'b0, accum_next} + {1'b0, add};
            if (sum[64]) begin
              p_valid = 1'b1; p_tok.kind = TK_ERROR; p_tok.status = ST_OVERFLOW;
              err_next = 1'b1; phase_next = PH_IDLE;
            end else begin
              accum_next = sum[63:0];
              shift_next = shift_next + SHIFT_STEP;
              if (!data_byte[7]) begin
                fin = 1'b1; fin_purpose = phase_next; fin_v = sum[63:0];
              end
            end
          end
        end
        PH_NAMELEN_HDR: begin
          huff_next = data_byte[7];
          st_go = 1'b1; st_purpose = PH_INT_NAMELEN; st_mask = 7'h7F;
        end
        PH_VALLEN_HDR: begin
          huff_next = data_byte[7];
          st_go = 1'b1; st_purpose = PH_INT_VALLEN; st_mask = 7'h7F;
        end
        PH_NAME_BYTES, PH_VALUE_BYTES: begin
          p_valid = 1'b1; p_tok.kind = TK_STR_BYTE;
          p_tok.mode = mode_next; p_tok.sbyte = data_byte;
          if (str_rem_next != '0) begin
            str_rem_next = str_rem_next - 64'd1;
          end
          if (str_rem_next == '0) begin
            phase_next = (phase_next == PH_NAME_BYTES) ? PH_VALLEN_HDR : PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // first byte of a prefix integer
      if (st_go) begin
        st_pv = data_byte[6:0] & st_mask;
        if (st_pv != st_mask) begin
          fin = 1'b1; fin_purpose = st_purpose; fin_v = {57'd0, st_pv};
        end else begin
          accum_next    = {57'd0, st_pv};
          shift_next    = '0;
          cont_cnt_next = '0;
          phase_next    = st_purpose;
        end
      end

      // completed integer
      if (fin) begin
        case (fin_purpose)
          PH_INT_INDEXED: begin
            p_valid = 1'b1;
            phase_next = PH_IDLE;
            if (fin_v == '0) begin
              p_tok.kind = TK_ERROR; p_tok.status = ST_INDEX0;
              err_next = 1'b1;
            end else begin
              p_tok.kind = TK_INDEXED; p_tok.value = fin_v;
            end
          end
          PH_INT_NAMEIDX: begin
            p_valid = 1'b1;
            p_tok.kind = TK_NAME_IDX; p_tok.value = fin_v; p_tok.mode = mode_next;
            phase_next = (fin_v == '0) ? PH_NAMELEN_HDR : PH_VALLEN_HDR;
          end
          PH_INT_UPDATE: begin
            p_valid = 1'b1;
            phase_next = PH_IDLE;
            if (fin_v[63:32] != '0 || fin_v[31:0] > table_limit) begin
              p_tok.kind = TK_ERROR; p_tok.status = ST_BAD_TABLE;
              err_next = 1'b1;
            end else begin
              p_tok.kind = TK_SIZE_UPD; p_tok.value = fin_v;
              upd_cnt_next = upd_cnt_next + 1'b1;
            end
          end
          PH_INT_NAMELEN: begin
            p_valid = 1'b1;
            p_tok.kind = TK_NAME_LEN; p_tok.value = fin_v;
            p_tok.huff = huff_next; p_tok.mode = mode_next;
            str_rem_next = fin_v;
            phase_next = (fin_v != '0) ? PH_NAME_BYTES : PH_VALLEN_HDR;
          end
          default: begin
            p_valid = 1'b1;
            p_tok.kind = TK_VAL_LEN; p_tok.value = fin_v;
            p_tok.huff = huff_next; p_tok.mode = mode_next;
            str_rem_next = fin_v;
            phase_next = (fin_v != '0) ? PH_VALUE_BYTES : PH_IDLE;
          end
        endcase
      end

      // end of block: clean close or truncation
      if (block_last && !err_next) begin
        e_valid = 1'b1;
        if (phase_next == PH_IDLE) begin
          e_tok.kind = TK_BLK_END;
        end else begin
          e_tok.kind = TK_ERROR; e_tok.status = ST_TRUNC;
        end
      end
    end

    // next byte always opens a fresh block after the last one
    if (block_last) begin
      phase_next       = PH_IDLE;
      accum_next       = '0;
      shift_next       = '0;
      cont_cnt_next    = '0;
      str_rem_next     = '0;
      mode_next        = MODE_WITH;
      upd_allowed_next = 1'b1;
      upd_cnt_next     = '0;
      err_next         = 1'b0;
      huff_next        = 1'b0;
    end

    // pack the results of this byte
    ent_valid = in_take && (p_valid || e_valid);
    ent.tok0  = p_valid ? p_tok : e_tok;
    ent.tok1  = e_tok;
    ent.two   = p_valid && e_valid;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accum       <= '0;
      shift       <= '0;
      cont_cnt    <= '0;
      str_rem     <= '0;
      mode        <= MODE_WITH;
      upd_allowed <= 1'b1;
      upd_cnt     <= '0;
      err         <= 1'b0;
      huff        <= 1'b0;
    end else if (in_take) begin
      phase       <= phase_next;
      accum       <= accum_next;
      shift       <= shift_next;
      cont_cnt    <= cont_cnt_next;
      str_rem     <= str_rem_next;
      mode        <= mode_next;
      upd_allowed <= upd_allowed_next;
      upd_cnt     <= upd_cnt_next;
      err         <= err_next;
      huff        <= huff_next;
    end
  end

endmodule

// ===== src/hpbt_queue.sv =====
`timescale 1ns / 1ps
// short queue of result entries between parser and output stage
// depends on hpbt_pkg

module hpbt_queue import hpbt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_data,
  input  logic   rd,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/hpbt_back.sv =====
`timescale 1ns / 1ps
// output stage: holds one entry and hands out its tokens one per pop
// depends on hpbt_pkg

module hpbt_back import hpbt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t q_data,
  input  logic   q_empty,
  output logic   q_rd,
  input  logic   pop,
  output logic   empty,
  output tok_t   tok,
  output logic   last_of_run
);

  entry_t cur;
  logic   valid;
  logic   sel;
  logic   done;

  // current token leaves and it is the final one of the entry
  assign done        = pop && valid && (sel || !cur.two);
  assign q_rd        = (!valid || done) && !q_empty;
  assign empty       = !valid;
  assign tok         = sel ? cur.tok1 : cur.tok0;
  assign last_of_run = sel || !cur.two;

  // held entry
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else if (q_rd) begin
      valid <= 1'b1;
      sel   <= 1'b0;
    end else if (done) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else if (pop && valid) begin
      sel <= 1'b1;
    end
  end

endmodule

// ===== sim/tb_hpack_header_block_tokenizer.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the header block tokenizer: a directed table, then
// random header blocks, each untyped token compared with a behavioural decoder
// in here; depends on hpbt_pkg and hpack_header_block_tokenizer

module tb_hpack_header_block_tokenizer;
  import hpbt_pkg::*;

  localparam int MAX_UPDATES   = 2;
  localparam int MAX_CONTS     = 10;
  localparam int PHASE_BYTES   = 200;
  localparam int NUM_PHASES    = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    tok_t tok;
    logic last;
  } token_exp_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        s;
    logic        l;
    logic        typed;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  status;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        block_start;
  logic        block_last;
  logic        pop;
  logic        empty;
  logic [2:0]  token_kind;
  logic [63:0] token_value;
  logic        huffman_flag;
  logic [1:0]  index_mode;
  logic [7:0]  string_byte;
  logic [2:0]  status;
  logic        last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // typed expectation travels with the item it belongs to
  logic        dir_typed;
  tok_t        dir_tok;
  logic        hold_req = 1'b0;

  int snd_idle;
  int rcv_idle;
  int mismatch_cnt;
  int tokens_seen;
  int error_tokens;
  int bytes_in;
  int blocks_sent;
  int stall_cycles;

  logic [31:0] cur_cfg;
  logic [7:0]  blk_bytes[$];
  token_exp_t  pending_tokens[$];
  tok_t        step_toks[$];

  // decoder state
  phase_t      prs_phase;
  logic [63:0] int_acc;
  int          int_shift;
  int          int_conts;
  logic [63:0] str_left;
  logic [1:0]  lit_mode;
  logic        upd_open;
  int          upd_seen;
  logic        blk_failed;
  logic        len_huff;
  logic [31:0] tbl_limit;

  // directed items: typed expectations only where the result is obvious
  dir_row_t dir_tab [28] = '{
    '{8'h82, 1'b1, 1'b0, 1'b1, TK_INDEXED,  64'd2,    ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b1, TK_ERROR,    64'd0,    ST_INDEX0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h2A, 1'b0, 1'b0, 1'b1, TK_SIZE_UPD, 64'd10,   ST_OK},
    '{8'h25, 1'b0, 1'b0, 1'b1, TK_SIZE_UPD, 64'd5,    ST_OK},
    '{8'h20, 1'b0, 1'b0, 1'b1, TK_ERROR,    64'd0,    ST_BAD_TABLE},
    '{8'h40, 1'b1, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h82, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h3F, 1'b1, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hE2, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h1F, 1'b0, 1'b0, 1'b1, TK_ERROR,    64'd0,    ST_BAD_TABLE},
    '{8'h11, 1'b1, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h01, 1'b1, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h05, 1'b0, 1'b1, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'h20, 1'b0, 1'b1, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, TK_INDEXED,  64'd0,    ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, TK_ERROR,    64'd0,    ST_OVERFLOW}
  };

  hpack_header_block_tokenizer dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .block_start    (block_start),
    .block_last     (block_last),
    .pop            (pop),
    .empty          (empty),
    .token_kind     (token_kind),
    .token_value    (token_value),
    .huffman_flag   (huffman_flag),
    .index_mode     (index_mode),
    .string_byte    (string_byte),
    .status         (status),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- decoder ----------------

  task automatic add_tok(input logic [2:0] kind, input logic [63:0] val, input logic huff,
                         input logic [1:0] mode, input logic [7:0] sb, input logic [2:0] st);
    tok_t t;
    if (step_toks.size() < 2) begin
      t.kind   = kind;
      t.value  = val;
      t.huff   = huff;
      t.mode   = mode;
      t.sbyte  = sb;
      t.status = st;
      step_toks.push_back(t);
    end
  endtask

  task automatic parse_fail(input logic [2:0] st);
    add_tok(TK_ERROR, '0, 1'b0, '0, '0, st);
    blk_failed = 1'b1;
    prs_phase  = PH_IDLE;
  endtask

  task automatic blk_clear();
    prs_phase  = PH_IDLE;
    int_acc    = '0;
    int_shift  = 0;
    int_conts  = 0;
    str_left   = '0;
    lit_mode   = MODE_WITH;
    upd_open   = 1'b1;
    upd_seen   = 0;
    blk_failed = 1'b0;
    len_huff   = 1'b0;
  endtask

  // a complete integer decides the next phase
  task automatic int_done(input phase_t purpose, input logic [63:0] v);
    case (purpose)
      PH_INT_INDEXED: begin
        if (v == 0) parse_fail(ST_INDEX0);
        else begin
          add_tok(TK_INDEXED, v, 1'b0, '0, '0, ST_OK);
          prs_phase = PH_IDLE;
        end
      end
      PH_INT_NAMEIDX: begin
        add_tok(TK_NAME_IDX, v, 1'b0, lit_mode, '0, ST_OK);
        prs_phase = (v == 0) ? PH_NAMELEN_HDR : PH_VALLEN_HDR;
      end
      PH_INT_UPDATE: begin
        if (v > {32'd0, tbl_limit}) parse_fail(ST_BAD_TABLE);
        else begin
          add_tok(TK_SIZE_UPD, v, 1'b0, '0, '0, ST_OK);
          if (upd_seen < 3) upd_seen++;
          prs_phase = PH_IDLE;
        end
      end
      PH_INT_NAMELEN: begin
        add_tok(TK_NAME_LEN, v, len_huff, lit_mode, '0, ST_OK);
        str_left  = v;
        prs_phase = (v != 0) ? PH_NAME_BYTES : PH_VALLEN_HDR;
      end
      default: begin
        add_tok(TK_VAL_LEN, v, len_huff, lit_mode, '0, ST_OK);
        str_left  = v;
        prs_phase = (v != 0) ? PH_VALUE_BYTES : PH_IDLE;
      end
    endcase
  endtask

  task automatic int_begin(input phase_t purpose, input logic [7:0] b, input logic [7:0] maxp);
    logic [7:0] v;
    v = b & maxp;
    if (v < maxp) int_done(purpose, {56'd0, v});
    else begin
      int_acc   = {56'd0, v};
      int_shift = 0;
      int_conts = 0;
      prs_phase = purpose;
    end
  endtask

  task automatic str_octet(input logic [7:0] b, input phase_t nxt);
    add_tok(TK_STR_BYTE, '0, 1'b0, lit_mode, b, ST_OK);
    if (str_left > 0) str_left--;
    if (str_left == 0) prs_phase = nxt;
  endtask

  // tokens caused by one accepted byte, left in step_toks
  task automatic decode_byte(input logic [7:0] b, input logic s, input logic l);
    logic [63:0] add;
    if (s) blk_clear();
    if (!blk_failed) begin
      case (prs_phase)
        PH_IDLE: begin
          if (b[7]) begin
            upd_open = 1'b0;
            int_begin(PH_INT_INDEXED, b, 8'h7F);
          end else if (b[7:6] == 2'b01) begin
            upd_open = 1'b0;
            lit_mode = MODE_WITH;
            int_begin(PH_INT_NAMEIDX, b, 8'h3F);
          end else if (b[7:4] == 4'h0) begin
            upd_open = 1'b0;
            lit_mode = MODE_WITHOUT;
            int_begin(PH_INT_NAMEIDX, b, 8'h0F);
          end else if (b[7:4] == 4'h1) begin
            upd_open = 1'b0;
            lit_mode = MODE_NEVER;
            int_begin(PH_INT_NAMEIDX, b, 8'h0F);
          end else if (!upd_open || upd_seen >= MAX_UPDATES) begin
            parse_fail(ST_BAD_TABLE);
          end else begin
            int_begin(PH_INT_UPDATE, b, 8'h1F);
          end
        end
        PH_INT_INDEXED, PH_INT_NAMEIDX, PH_INT_UPDATE, PH_INT_NAMELEN, PH_INT_VALLEN: begin
          // continuation byte of a prefix integer
          if (int_conts >= MAX_CONTS || int_shift > int'(SHIFT_LIMIT)) begin
            parse_fail(ST_OVERFLOW);
          end else begin
            int_conts++;
            add = {57'd0, b[6:0]} << int_shift;
            if (int_acc > ~add) parse_fail(ST_OVERFLOW);
            else begin
              int_acc   = int_acc + add;
              int_shift = int_shift + int'(SHIFT_STEP);
              if (!b[7]) int_done(prs_phase, int_acc);
            end
          end
        end
        PH_NAMELEN_HDR: begin
          len_huff = b[7];
          int_begin(PH_INT_NAMELEN, b, 8'h7F);
        end
        PH_VALLEN_HDR: begin
          len_huff = b[7];
          int_begin(PH_INT_VALLEN, b, 8'h7F);
        end
        PH_NAME_BYTES:  str_octet(b, PH_VALLEN_HDR);
        PH_VALUE_BYTES: str_octet(b, PH_IDLE);
        default:        prs_phase = PH_IDLE;
      endcase
      if (l && !blk_failed) begin
        if (prs_phase == PH_IDLE) add_tok(TK_BLK_END, '0, 1'b0, '0, '0, ST_OK);
        else add_tok(TK_ERROR, '0, 1'b0, '0, '0, ST_TRUNC);
      end
    end
    if (l) blk_clear();
  endtask

  // ---------------- checking ----------------

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h (token %0d)",
               $time, what, got, want, tokens_seen);
  endtask

  // sample every handshake at the edge
  always @(posedge clk) begin : monitor
    token_exp_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tbl_limit = cfg_data;
      if (push && !full) begin
        step_toks.delete();
        decode_byte(data_byte, block_start, block_last);
        if (dir_typed) begin
          step_toks.delete();
          step_toks.push_back(dir_tok);
        end
        foreach (step_toks[i]) begin
          e.tok  = step_toks[i];
          e.last = (i == step_toks.size() - 1);
          pending_tokens.push_back(e);
        end
        bytes_in++;
      end
      if (pop && !empty) begin
        if (pending_tokens.size() == 0) begin
          report("token with nothing pending, kind", 64'(token_kind), '0);
        end else begin
          e = pending_tokens.pop_front();
          if (token_kind !== e.tok.kind)
            report("token_kind", 64'(token_kind), 64'(e.tok.kind));
          if (token_value !== e.tok.value)
            report("token_value", token_value, e.tok.value);
          if (huffman_flag !== e.tok.huff)
            report("huffman_flag", 64'(huffman_flag), 64'(e.tok.huff));
          if (index_mode !== e.tok.mode)
            report("index_mode", 64'(index_mode), 64'(e.tok.mode));
          if (string_byte !== e.tok.sbyte)
            report("string_byte", 64'(string_byte), 64'(e.tok.sbyte));
          if (status !== e.tok.status)
            report("status", 64'(status), 64'(e.tok.status));
          if (last_of_run !== e.last)
            report("last_of_run", 64'(last_of_run), 64'(e.last));
        end
        tokens_seen++;
        if (token_kind == TK_ERROR) error_tokens++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d tokens pending",
               stall_cycles, pending_tokens.size());
      $display("tb_hpack_header_block_tokenizer: errors");
      $finish;
    end
  end

  // result side: random pop, with a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_byte(input logic [7:0] b, input logic s, input logic l,
                           input logic typed, input tok_t t);
    push        <= 1'b1;
    data_byte   <= b;
    block_start <= s;
    block_last  <= l;
    dir_typed   <= typed;
    dir_tok     <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    if ($urandom_range(0, 99) < snd_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
  endtask

  // stop sending until every pending token is out and the pipe is quiet
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_int(input logic [7:0] hi, input logic [7:0] maxp, input logic [63:0] v);
    logic [63:0] rest;
    if (v < {56'd0, maxp}) begin
      blk_bytes.push_back(hi | v[7:0]);
    end else begin
      blk_bytes.push_back(hi | maxp);
      rest = v - {56'd0, maxp};
      while (rest >= 128) begin
        blk_bytes.push_back({1'b1, rest[6:0]});
        rest = rest >> 7;
      end
      blk_bytes.push_back({1'b0, rest[6:0]});
    end
  endtask

  task automatic put_string();
    int len;
    len = $urandom_range(0, 5);
    put_int({1'($urandom_range(0, 1)), 7'd0}, 8'h7F, 64'(len));
    repeat (len) blk_bytes.push_back(8'($urandom));
  endtask

  initial begin : stimulus
    tok_t        t;
    int          p;
    int          phase_sent;
    int          n_upd;
    int          n_fld;
    int          pick;
    int          cut;
    logic [1:0]  mode;
    logic [63:0] v;
    logic        s_flag;
    logic        l_flag;
    logic [31:0] lim;

    rst            = 1'b1;
    push           = 1'b0;
    data_byte      = '0;
    block_start    = 1'b0;
    block_last     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    dir_typed      = 1'b0;
    dir_tok        = '0;
    snd_idle       = 26;
    rcv_idle       = 88;
    cur_cfg        = TABLE_SIZE_RESET;
    tbl_limit      = TABLE_SIZE_RESET;
    blk_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      t        = '0;
      t.kind   = dir_tab[i].kind;
      t.value  = dir_tab[i].value;
      t.status = dir_tab[i].status;
      send_byte(dir_tab[i].b, dir_tab[i].s, dir_tab[i].l, dir_tab[i].typed, t);
    end
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      snd_idle = (p < 3) ? 26 : (p < 6) ? 88 : 0;
      rcv_idle = (p < 3) ? 88 : (p < 6) ? 26 : 0;

      // new table limit while the block is quiet
      case (p)
        0:       lim = 32'd0;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = TABLE_SIZE_RESET;
        3:       lim = 32'($urandom_range(1, 300));
        4:       lim = $urandom;
        5:       lim = 32'd31;
        6:       lim = TABLE_SIZE_RESET;
        default: lim = 32'd127;
      endcase
      cfg_valid <= 1'b1;
      cfg_data  <= lim;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      cur_cfg = lim;

      // receiver holds off while bytes keep coming
      if (p == 2 || p == 6) hold_req = 1'b1;

      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        blk_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
          // noise block
          repeat ($urandom_range(1, 8)) blk_bytes.push_back(8'($urandom));
        end else begin
          // size updates at the head, sometimes too many
          pick  = $urandom_range(0, 9);
          n_upd = (pick < 6) ? 0 : (pick < 8) ? 1 : pick - 6;
          repeat (n_upd) begin
            pick = $urandom_range(0, 5);
            case (pick)
              0:       v = '0;
              1:       v = 64'(cur_cfg);
              2:       v = 64'(cur_cfg) + 64'd1;
              3:       v = 64'($urandom);
              default: v = 64'($urandom_range(0, 60));
            endcase
            put_int(8'h20, 8'h1F, v);
          end
          n_fld = $urandom_range(0, 4);
          repeat (n_fld) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
              // indexed field, with zero, prefix boundary and huge indices
              pick = $urandom_range(0, 19);
              if (pick == 0) v = '0;
              else if (pick == 1) v = 64'd127;
              else if (pick < 4) v = {$urandom, $urandom} >> $urandom_range(0, 63);
              else v = 64'($urandom_range(1, 70));
              put_int(8'h80, 8'h7F, v);
            end else if (pick < 9) begin
              // literal field
              mode = 2'($urandom_range(0, 2));
              v = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(1, 70));
              case (mode)
                MODE_WITH:    put_int(8'h40, 8'h3F, v);
                MODE_WITHOUT: put_int(8'h00, 8'h0F, v);
                default:      put_int(8'h10, 8'h0F, v);
              endcase
              if (v == 0) put_string();
              put_string();
            end else begin
              // size update among the fields
              put_int(8'h20, 8'h1F, 64'($urandom_range(0, 31)));
            end
          end
          // cut some blocks short
          if (blk_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, blk_bytes.size() - 1);
            while (blk_bytes.size() > cut) void'(blk_bytes.pop_back());
          end
        end
        if (blk_bytes.size() == 0) blk_bytes.push_back(8'($urandom));

        s_flag = ($urandom_range(0, 9) != 0);
        l_flag = ($urandom_range(0, 19) != 0);
        foreach (blk_bytes[i])
          send_byte(blk_bytes[i], (i == 0) ? s_flag : 1'b0,
                    (i == blk_bytes.size() - 1) ? l_flag : 1'b0, 1'b0, '0);
        phase_sent += blk_bytes.size();
        blocks_sent++;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d bytes (%0d random blocks), %0d tokens compared",
             bytes_in, blocks_sent, tokens_seen);
    $display("  %0d error tokens, table limits from 0 to ffffffff, long result stalls",
             error_tokens);
    if (mismatch_cnt == 0 && pending_tokens.size() == 0) begin
      $display("tb_hpack_header_block_tokenizer: clean");
    end else begin
      $display("tb_hpack_header_block_tokenizer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hpbt_pkg.sv
src/hpbt_front.sv
src/hpbt_queue.sv
src/hpbt_back.sv
src/hpack_header_block_tokenizer.sv
sim/tb_hpack_header_block_tokenizer.sv
